@@ hdl/assert_macros.svh @@
// shared assertion macros, clocked on clk and quiet while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define CHK_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// antecedent implies consequent in the next cycle
`define CHK_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

@@ hdl/cosdo_pkg.sv @@
package cosdo_pkg;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_READ  = 2'd1,
		PH_WRITE = 2'd2
	} cosdo_phase_t;

	typedef enum logic [2:0] {
		CMD_NMT     = 3'd0,
		CMD_SYNC    = 3'd1,
		CMD_READ    = 3'd2,
		CMD_WRITE   = 3'd3,
		CMD_RX      = 3'd4,
		CMD_RX_FAIL = 3'd5,
		CMD_TX_FAIL = 3'd6
	} cosdo_cmd_t;

	localparam logic [1:0] REG_READ_TMO   = 2'd0;
	localparam logic [1:0] REG_WRITE_TMO  = 2'd1;
	localparam logic [1:0] REG_ERR_LIMIT  = 2'd2;
	localparam logic [1:0] REG_MISM_LIMIT = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_TX_FAIL = 2'd1;
	localparam logic [1:0] ST_RX_FAIL = 2'd2;
	localparam logic [1:0] ST_BAD     = 2'd3;

	localparam logic [10:0] ID_NMT      = 11'h000;
	localparam logic [10:0] ID_SYNC     = 11'h080;
	localparam logic [10:0] ID_SDO_TX   = 11'h600;
	localparam logic [10:0] ID_SDO_RX   = 11'h580;
	localparam logic [7:0]  SDO_UPLOAD  = 8'h40;
	localparam logic [7:0]  SDO_DNLOAD4 = 8'h23;
	localparam logic [7:0]  SDO_WR_ACK  = 8'h60;
	localparam logic [7:0]  SDO_EXP_MIN = 8'h43;
	localparam logic [2:0]  CCS_UPLOAD  = 3'd2;

	typedef struct packed {
		logic [2:0]  command;
		logic [6:0]  node_id;
		logic [2:0]  nmt_action;
		logic [15:0] object_index;
		logic [7:0]  object_subindex;
		logic [31:0] write_data;
		logic [2:0]  write_length;
		logic [10:0] rx_id;
		logic        rx_error_flag;
		logic [63:0] rx_data;
	} cosdo_req_t;

	typedef struct packed {
		logic        result_kind;
		logic [10:0] tx_id;
		logic [3:0]  tx_dlc;
		logic [63:0] tx_data;
		logic [31:0] rx_timeout_ns;
		logic [1:0]  status;
		logic [31:0] read_data;
		logic [2:0]  read_length;
	} cosdo_rsp_t;

	typedef struct packed {
		logic [31:0] read_timeout_ns;
		logic [31:0] write_timeout_ns;
		logic [7:0]  error_retry_limit;
		logic [7:0]  mismatch_retry_limit;
	} cosdo_cfg_t;

	// nmt command specifier per action, zero for unknown actions
	function automatic logic [7:0] nmt_code(input logic [2:0] act);
		logic [7:0] code;
		case (act)
			3'd0: code = 8'h01;
			3'd1: code = 8'h02;
			3'd2: code = 8'h80;
			3'd3: code = 8'h81;
			3'd4: code = 8'h82;
			default: code = 8'h00;
		endcase
		return code;
	endfunction

endpackage

@@ hdl/canopen_sdo_nmt_master_unit.sv @@
// path: an accepted request passes the input register and then the result register before its result shows on rsp
// throughput: one request per cycle while req_stall is low; requests that produce no result still take one slot
// req_stall rises only while the result register holds a transaction that rsp_stall keeps
// reset (arst_n low): idle, no exchange pending, retry count cleared, config registers at defaults
module canopen_sdo_nmt_master_unit import cosdo_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        req_valid,
	output logic        req_stall,
	input  cosdo_req_t  req,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output cosdo_rsp_t  rsp
);

	cosdo_cfg_t cfg;
	logic       advance;
	logic       res_valid;
	cosdo_rsp_t res;

	cosdo_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	cosdo_step u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req       (req),
		.req_stall (req_stall),
		.cfg       (cfg),
		.advance   (advance),
		.res_valid (res_valid),
		.res       (res)
	);

	cosdo_outreg u_outreg (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.ready     (advance),
		.rsp_valid (rsp_valid),
		.rsp       (rsp),
		.rsp_stall (rsp_stall)
	);

endmodule

@@ hdl/cosdo_cfg.sv @@
module cosdo_cfg import cosdo_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output cosdo_cfg_t  cfg
);

	cosdo_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.read_timeout_ns      <= 32'd1000000000;
			cfg_q.write_timeout_ns     <= 32'd500000000;
			cfg_q.error_retry_limit    <= 8'd100;
			cfg_q.mismatch_retry_limit <= 8'd5;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_READ_TMO:   cfg_q.read_timeout_ns      <= cfg_data;
				REG_WRITE_TMO:  cfg_q.write_timeout_ns     <= cfg_data;
				REG_ERR_LIMIT:  cfg_q.error_retry_limit    <= cfg_data[7:0];
				REG_MISM_LIMIT: cfg_q.mismatch_retry_limit <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ hdl/cosdo_step.sv @@
`include "assert_macros.svh"

module cosdo_step import cosdo_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  cosdo_req_t req,
	output logic       req_stall,
	input  cosdo_cfg_t cfg,
	input  logic       advance,
	output logic       res_valid,
	output cosdo_rsp_t res
);

	logic         valid_s1;
	cosdo_req_t   req_s1;
	logic         fire_s1;
	logic         has_result;

	cosdo_phase_t phase_q, phase_d;
	logic [6:0]   pending_node_q, pending_node_d;
	logic [15:0]  pending_index_q, pending_index_d;
	logic [7:0]   try_count_q, try_count_d;

	logic [7:0]   try_inc;
	logic         rx_own;
	logic [2:0]   wlen;
	logic [2:0]   wlen_gap;
	logic [31:0]  wpayload;
	logic [7:0]   b0;
	logic [4:0]   excess;
	logic [2:0]   quarter;
	logic [2:0]   rd_len;
	logic         rd_hold;
	logic         wr_hold;
	logic         wr_ok;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || advance) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if ((!valid_s1 || advance) && req_valid) begin
			req_s1 <= req;
		end
	end

	assign req_stall = valid_s1 && !advance;
	assign fire_s1   = valid_s1 && advance;

	// shared decode
	assign try_inc = try_count_q + 8'd1;
	assign rx_own  = !req_s1.rx_error_flag &&
		(req_s1.rx_id == (ID_SDO_RX + {4'd0, pending_node_q}));
	assign rd_hold = req_s1.rx_error_flag && (try_inc < cfg.error_retry_limit);
	assign wr_hold = !rx_own && (try_inc < cfg.mismatch_retry_limit);

	always_comb begin
		if (req_s1.write_length == 3'd0)
			wlen = 3'd1;
		else if (req_s1.write_length > 3'd4)
			wlen = 3'd4;
		else
			wlen = req_s1.write_length;
	end

	assign wlen_gap = 3'd4 - wlen;

	always_comb begin
		case (wlen)
			3'd1: wpayload = {24'd0, req_s1.write_data[7:0]};
			3'd2: wpayload = {16'd0, req_s1.write_data[15:0]};
			3'd3: wpayload = {8'd0, req_s1.write_data[23:0]};
			default: wpayload = req_s1.write_data;
		endcase
	end

	// expedited upload length: 4 - (byte0 - 0x43) / 4, floored at zero
	assign b0      = req_s1.rx_data[7:0];
	assign excess  = (b0 < SDO_EXP_MIN) ? 5'd0 : (b0[4:0] - SDO_EXP_MIN[4:0]);
	assign quarter = excess[4:2];
	assign rd_len  = (quarter >= 3'd4) ? 3'd0 : (3'd4 - quarter);

	assign wr_ok = (b0 == SDO_WR_ACK) &&
		(req_s1.rx_data[15:8] == pending_index_q[7:0]) &&
		(req_s1.rx_data[23:16] == pending_index_q[15:8]);

	// next state
	always_comb begin
		phase_d         = phase_q;
		pending_node_d  = pending_node_q;
		pending_index_d = pending_index_q;
		try_count_d     = try_count_q;
		case (req_s1.command)
			CMD_READ, CMD_WRITE: begin
				if (phase_q == PH_IDLE) begin
					phase_d         = (req_s1.command == CMD_READ) ? PH_READ : PH_WRITE;
					pending_node_d  = req_s1.node_id;
					pending_index_d = req_s1.object_index;
					try_count_d     = 8'd0;
				end
			end
			CMD_RX: begin
				case (phase_q)
					PH_READ: begin
						try_count_d = try_inc;
						if (!rd_hold)
							phase_d = PH_IDLE;
					end
					PH_WRITE: begin
						if (rx_own) begin
							phase_d = PH_IDLE;
						end else begin
							try_count_d = try_inc;
							if (!wr_hold)
								phase_d = PH_IDLE;
						end
					end
					default: ;
				endcase
			end
			CMD_RX_FAIL, CMD_TX_FAIL: begin
				phase_d = PH_IDLE;
			end
			default: ;
		endcase
	end

	// result
	always_comb begin
		has_result = 1'b0;
		res        = '0;
		case (req_s1.command)
			CMD_NMT: begin
				if (req_s1.nmt_action <= 3'd4) begin
					has_result  = 1'b1;
					res.tx_id   = ID_NMT;
					res.tx_dlc  = 4'd2;
					res.tx_data = {48'd0, 1'b0, req_s1.node_id, nmt_code(req_s1.nmt_action)};
				end
			end
			CMD_SYNC: begin
				has_result = 1'b1;
				res.tx_id  = ID_SYNC;
			end
			CMD_READ: begin
				if (phase_q == PH_IDLE) begin
					has_result        = 1'b1;
					res.tx_id         = ID_SDO_TX + {4'd0, req_s1.node_id};
					res.tx_dlc        = 4'd8;
					res.tx_data       = {32'd0, req_s1.object_subindex,
						req_s1.object_index, SDO_UPLOAD};
					res.rx_timeout_ns = cfg.read_timeout_ns;
				end
			end
			CMD_WRITE: begin
				if (phase_q == PH_IDLE) begin
					has_result        = 1'b1;
					res.tx_id         = ID_SDO_TX + {4'd0, req_s1.node_id};
					res.tx_dlc        = 4'd8;
					res.tx_data       = {wpayload, req_s1.object_subindex, req_s1.object_index,
						SDO_DNLOAD4 + {3'd0, wlen_gap, 2'b00}};
					res.rx_timeout_ns = cfg.write_timeout_ns;
				end
			end
			CMD_RX: begin
				case (phase_q)
					PH_READ: begin
						if (!rd_hold) begin
							has_result      = 1'b1;
							res.result_kind = 1'b1;
							if (b0[7:5] == CCS_UPLOAD) begin
								res.status      = ST_OK;
								res.read_data   = req_s1.rx_data[63:32];
								res.read_length = rd_len;
							end else begin
								res.status = ST_BAD;
							end
						end
					end
					PH_WRITE: begin
						if (rx_own || !wr_hold) begin
							has_result      = 1'b1;
							res.result_kind = 1'b1;
							res.status      = wr_ok ? ST_OK : ST_BAD;
						end
					end
					default: ;
				endcase
			end
			CMD_RX_FAIL: begin
				if (phase_q != PH_IDLE) begin
					has_result      = 1'b1;
					res.result_kind = 1'b1;
					res.status      = ST_RX_FAIL;
				end
			end
			CMD_TX_FAIL: begin
				if (phase_q != PH_IDLE) begin
					has_result      = 1'b1;
					res.result_kind = 1'b1;
					res.status      = ST_TX_FAIL;
				end
			end
			default: ;
		endcase
	end

	assign res_valid = valid_s1 && has_result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_IDLE;
			pending_node_q  <= 7'd0;
			pending_index_q <= 16'd0;
			try_count_q     <= 8'd0;
		end else if (fire_s1) begin
			phase_q         <= phase_d;
			pending_node_q  <= pending_node_d;
			pending_index_q <= pending_index_d;
			try_count_q     <= try_count_d;
		end
	end

	`CHK_IMP(a_done_needs_busy, fire_s1 && has_result && res.result_kind, phase_q != PH_IDLE)
	`CHK_NEXT(a_done_goes_idle, fire_s1 && has_result && res.result_kind, phase_q == PH_IDLE)
	`CHK_NEXT(a_request_arms_busy, fire_s1 && has_result && (res.tx_dlc == 4'd8), phase_q != PH_IDLE)

endmodule

@@ hdl/cosdo_outreg.sv @@
module cosdo_outreg import cosdo_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       res_valid,
	input  cosdo_rsp_t res,
	output logic       ready,
	output logic       rsp_valid,
	output cosdo_rsp_t rsp,
	input  logic       rsp_stall
);

	logic       rsp_valid_q;
	cosdo_rsp_t rsp_q;

	// free when empty or when the held transaction leaves this cycle
	assign ready = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ready) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && res_valid) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

@@ bench/tb.sv @@
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import cosdo_pkg::*;

	localparam logic [2:0] CMD_UNUSED = 3'd7;
	localparam logic [7:0] NMT_CS [5] = '{8'h01, 8'h02, 8'h80, 8'h81, 8'h82};
	localparam int WATCHDOG_LIMIT = 4000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = REG_READ_TMO;
	logic [31:0] cfg_data = '0;
	logic req_valid = 1'b0;
	logic req_stall;
	cosdo_req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	cosdo_rsp_t rsp;

	// mirror of the master's registers and exchange state
	cosdo_cfg_t model_cfg = '{32'd1000000000, 32'd500000000, 8'd100, 8'd5};
	cosdo_phase_t eng_phase = PH_IDLE;
	logic [6:0] eng_node = '0;
	logic [15:0] eng_index = '0;
	logic [7:0] eng_tries = '0;

	cosdo_req_t pending_req [$];
	cosdo_rsp_t awaited_rsp [$];

	logic req_taken = 1'b0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int quiet_cycles = 0;
	int n_err = 0;
	int n_req = 0;
	int n_rsp = 0;
	int n_done = 0;

	canopen_sdo_nmt_master_unit dut (
		.clk,
		.arst_n,
		.cfg_we,
		.cfg_index,
		.cfg_data,
		.req_valid,
		.req_stall,
		.req,
		.rsp_valid,
		.rsp_stall,
		.rsp
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// expected output of the master for one request, updates the mirrored state
	function automatic bit predict_master(input cosdo_req_t r, output cosdo_rsp_t o);
		logic [2:0] len;
		logic [31:0] pay;
		logic [7:0] b0;
		logic [7:0] q;
		logic [1:0] st;
		bit hit;
		bit done;
		bit matched;
		o = '0;
		hit = 1'b0;
		done = 1'b0;
		st = ST_OK;
		case (r.command)
			CMD_NMT: begin
				if (r.nmt_action <= 3'd4) begin
					hit = 1'b1;
					o.tx_id = ID_NMT;
					o.tx_dlc = 4'd2;
					o.tx_data = {48'd0, 1'b0, r.node_id, NMT_CS[r.nmt_action]};
				end
			end
			CMD_SYNC: begin
				hit = 1'b1;
				o.tx_id = ID_SYNC;
			end
			CMD_READ: begin
				if (eng_phase == PH_IDLE) begin
					eng_phase = PH_READ;
					eng_node = r.node_id;
					eng_index = r.object_index;
					eng_tries = '0;
					hit = 1'b1;
					o.tx_id = ID_SDO_TX + {4'd0, r.node_id};
					o.tx_dlc = 4'd8;
					o.tx_data = {32'd0, r.object_subindex, r.object_index, SDO_UPLOAD};
					o.rx_timeout_ns = model_cfg.read_timeout_ns;
				end
			end
			CMD_WRITE: begin
				if (eng_phase == PH_IDLE) begin
					len = r.write_length;
					if (len == 3'd0) len = 3'd1;
					if (len > 3'd4) len = 3'd4;
					pay = r.write_data;
					if (len < 3'd4) pay = pay & ((32'd1 << (8 * len)) - 32'd1);
					eng_phase = PH_WRITE;
					eng_node = r.node_id;
					eng_index = r.object_index;
					eng_tries = '0;
					hit = 1'b1;
					o.tx_id = ID_SDO_TX + {4'd0, r.node_id};
					o.tx_dlc = 4'd8;
					o.tx_data = {pay, r.object_subindex, r.object_index,
						8'(SDO_DNLOAD4 + 4 * (4 - len))};
					o.rx_timeout_ns = model_cfg.write_timeout_ns;
				end
			end
			CMD_RX: begin
				if (eng_phase == PH_READ) begin
					eng_tries = eng_tries + 8'd1;
					if (!(r.rx_error_flag && eng_tries < model_cfg.error_retry_limit)) begin
						done = 1'b1;
						b0 = r.rx_data[7:0];
						if (b0[7:5] != CCS_UPLOAD) begin
							st = ST_BAD;
						end else begin
							q = (b0 < SDO_EXP_MIN) ? 8'd0 : ((b0 - SDO_EXP_MIN) >> 2);
							o.read_data = r.rx_data[63:32];
							o.read_length = (q >= 8'd4) ? 3'd0 : 3'(4 - q);
						end
					end
				end else if (eng_phase == PH_WRITE) begin
					matched = !r.rx_error_flag && r.rx_id == ID_SDO_RX + {4'd0, eng_node};
					if (!matched) eng_tries = eng_tries + 8'd1;
					if (matched || eng_tries >= model_cfg.mismatch_retry_limit) begin
						done = 1'b1;
						if (!(r.rx_data[7:0] == SDO_WR_ACK && r.rx_data[23:8] == eng_index))
							st = ST_BAD;
					end
				end
			end
			CMD_RX_FAIL: begin
				if (eng_phase != PH_IDLE) begin
					done = 1'b1;
					st = ST_RX_FAIL;
				end
			end
			CMD_TX_FAIL: begin
				if (eng_phase != PH_IDLE) begin
					done = 1'b1;
					st = ST_TX_FAIL;
				end
			end
			default: ;
		endcase
		if (done) begin
			o.result_kind = 1'b1;
			o.status = st;
			eng_phase = PH_IDLE;
			hit = 1'b1;
		end
		return hit;
	endfunction

	function automatic int field_diff(input string name, input logic [63:0] e,
			input logic [63:0] a);
		if (a !== e) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, e, a);
			return 1;
		end
		return 0;
	endfunction

	function automatic cosdo_req_t rand_item();
		cosdo_req_t r;
		r.command = 3'($urandom);
		r.node_id = 7'($urandom);
		r.nmt_action = 3'($urandom);
		r.object_index = 16'($urandom);
		r.object_subindex = 8'($urandom);
		r.write_data = $urandom;
		r.write_length = 3'($urandom);
		r.rx_id = 11'($urandom);
		r.rx_error_flag = 1'($urandom);
		r.rx_data = {$urandom, $urandom};
		return r;
	endfunction

	function automatic cosdo_req_t mk(input logic [2:0] c);
		cosdo_req_t r;
		r = rand_item();
		r.command = c;
		return r;
	endfunction

	function automatic cosdo_req_t nmt_req(input logic [2:0] act, input logic [6:0] nd);
		cosdo_req_t r;
		r = mk(CMD_NMT);
		r.nmt_action = act;
		r.node_id = nd;
		return r;
	endfunction

	function automatic cosdo_req_t sdo_req(input logic [2:0] c, input logic [6:0] nd,
			input logic [15:0] ix, input logic [7:0] sub, input logic [31:0] wd,
			input logic [2:0] wl);
		cosdo_req_t r;
		r = mk(c);
		r.node_id = nd;
		r.object_index = ix;
		r.object_subindex = sub;
		r.write_data = wd;
		r.write_length = wl;
		return r;
	endfunction

	function automatic cosdo_req_t rx_frame(input logic err, input logic [10:0] id,
			input logic [63:0] data);
		cosdo_req_t r;
		r = mk(CMD_RX);
		r.rx_error_flag = err;
		r.rx_id = id;
		r.rx_data = data;
		return r;
	endfunction

	// feeds the request channel, holds a stalled transaction steady
	always @(negedge clk) begin
		if (arst_n) begin
			if (!req_valid || req_taken) begin
				if (pending_req.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					req <= pending_req.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
			rsp_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cosdo_rsp_t nxt;
		cosdo_rsp_t want;
		if (arst_n) begin
			req_taken <= req_valid && !req_stall;
			if (req_valid && !req_stall) begin
				n_req++;
				if (predict_master(req, nxt))
					awaited_rsp.push_back(nxt);
			end
			if (rsp_valid && !rsp_stall) begin
				if (awaited_rsp.size() == 0) begin
					$error("result transaction with none outstanding: %p", rsp);
					n_err++;
				end else begin
					want = awaited_rsp.pop_front();
					n_rsp++;
					if (want.result_kind) n_done++;
					n_err += field_diff("result_kind", want.result_kind, rsp.result_kind);
					n_err += field_diff("tx_id", want.tx_id, rsp.tx_id);
					n_err += field_diff("tx_dlc", want.tx_dlc, rsp.tx_dlc);
					n_err += field_diff("tx_data", want.tx_data, rsp.tx_data);
					n_err += field_diff("rx_timeout_ns", want.rx_timeout_ns, rsp.rx_timeout_ns);
					n_err += field_diff("status", want.status, rsp.status);
					n_err += field_diff("read_data", want.read_data, rsp.read_data);
					n_err += field_diff("read_length", want.read_length, rsp.read_length);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("** canopen_sdo_nmt_master_unit: FAILED **");
			$finish;
		end
	end

	// all requests accepted and all results in, then a settling margin for ignored ones
	task automatic settle();
		@(posedge clk);
		while (pending_req.size() != 0 || req_valid || awaited_rsp.size() != 0)
			@(posedge clk);
		repeat (5) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
	endtask

	task automatic set_config(input logic [31:0] rt, input logic [31:0] wt,
			input logic [7:0] el, input logic [7:0] ml);
		settle();
		write_reg(REG_READ_TMO, rt);
		write_reg(REG_WRITE_TMO, wt);
		write_reg(REG_ERR_LIMIT, {24'd0, el});
		write_reg(REG_MISM_LIMIT, {24'd0, ml});
		@(negedge clk);
		cfg_we = 1'b0;
		model_cfg = '{rt, wt, el, ml};
	endtask

	// mostly complete exchanges with random content, plus loose frames and noise
	task automatic push_random(input int target);
		int made;
		int k;
		int pick;
		int lim;
		cosdo_req_t r;
		logic [6:0] nd;
		logic [15:0] ix;
		made = 0;
		while (made < target) begin
			pick = $urandom_range(99);
			if (pick < 40) begin
				r = mk(CMD_READ);
				pending_req.push_back(r);
				lim = int'(model_cfg.error_retry_limit);
				k = ($urandom_range(7) == 0) ? $urandom_range(lim + 1) : $urandom_range(3);
				for (int i = 0; i < k; i++)
					pending_req.push_back(rx_frame(1'b1, 11'($urandom), {$urandom, $urandom}));
				pick = $urandom_range(99);
				if (pick < 70) begin
					r = rx_frame($urandom_range(9) == 0, 11'($urandom), {$urandom, $urandom});
					if ($urandom_range(9) != 0) r.rx_data[7:5] = CCS_UPLOAD;
				end else begin
					r = mk(pick < 85 ? CMD_RX_FAIL : CMD_TX_FAIL);
				end
				pending_req.push_back(r);
				made += k + 2;
			end else if (pick < 75) begin
				r = mk(CMD_WRITE);
				r.write_length = ($urandom_range(9) == 0) ? 3'($urandom)
					: 3'($urandom_range(1, 4));
				nd = r.node_id;
				ix = r.object_index;
				pending_req.push_back(r);
				lim = int'(model_cfg.mismatch_retry_limit);
				k = ($urandom_range(7) == 0) ? $urandom_range(lim + 1) : $urandom_range(3);
				for (int i = 0; i < k; i++) begin
					r = rx_frame(1'($urandom), 11'($urandom), {$urandom, $urandom});
					if (!r.rx_error_flag && r.rx_id == ID_SDO_RX + {4'd0, nd})
						r.rx_id[10] = ~r.rx_id[10];
					if ($urandom_range(2) == 0) r.rx_data[23:0] = {ix, SDO_WR_ACK};
					pending_req.push_back(r);
				end
				pick = $urandom_range(99);
				if (pick < 70) begin
					r = rx_frame(1'b0, ID_SDO_RX + {4'd0, nd}, {$urandom, $urandom});
					case ($urandom_range(4))
						0, 1, 2: r.rx_data[23:0] = {ix, SDO_WR_ACK};
						3: r.rx_data[7:0] = SDO_WR_ACK;
						default: ;
					endcase
				end else begin
					r = mk(pick < 85 ? CMD_RX_FAIL : CMD_TX_FAIL);
				end
				pending_req.push_back(r);
				made += k + 2;
			end else if (pick < 85) begin
				pending_req.push_back(mk($urandom_range(1) ? CMD_NMT : CMD_SYNC));
				made++;
			end else begin
				pending_req.push_back(rand_item());
				made++;
			end
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset defaults: frame builders, ignored requests, each end of an exchange
		send_idle_pct = 20;
		recv_stall_pct = 46;
		pending_req.push_back(nmt_req(3'd0, 7'd0));
		pending_req.push_back(nmt_req(3'd1, 7'd127));
		pending_req.push_back(nmt_req(3'd2, 7'h55));
		pending_req.push_back(nmt_req(3'd3, 7'h2a));
		pending_req.push_back(nmt_req(3'd4, 7'd127));
		pending_req.push_back(nmt_req(3'd5, 7'd1));
		pending_req.push_back(mk(CMD_SYNC));
		pending_req.push_back(mk(CMD_UNUSED));
		pending_req.push_back(rx_frame(1'b0, ID_SDO_RX, {$urandom, $urandom}));
		pending_req.push_back(mk(CMD_TX_FAIL));
		pending_req.push_back(sdo_req(CMD_READ, 7'd127, 16'hffff, 8'hff, '1, '1));
		pending_req.push_back(rx_frame(1'b1, 11'h5ff, {$urandom, $urandom}));
		pending_req.push_back(nmt_req(3'd2, 7'd0));
		pending_req.push_back(sdo_req(CMD_READ, 7'd1, 16'h1000, 8'h00, '0, '0));
		pending_req.push_back(sdo_req(CMD_WRITE, 7'd2, 16'h2000, 8'h01, '0, 3'd4));
		pending_req.push_back(rx_frame(1'b0, 11'h5ff, {32'hffffffff, 24'h0, 8'h4f}));
		pending_req.push_back(sdo_req(CMD_READ, 7'd0, 16'h0000, 8'h00, '0, '0));
		pending_req.push_back(rx_frame(1'b0, 11'h580, {$urandom, 24'h0, 8'h5f}));
		pending_req.push_back(sdo_req(CMD_WRITE, 7'd5, 16'h1234, 8'h00, '1, 3'd0));
		pending_req.push_back(rx_frame(1'b1, 11'h585, {40'h0, 24'h123460}));
		pending_req.push_back(rx_frame(1'b0, 11'h585, {40'h0, 24'h123460}));
		pending_req.push_back(sdo_req(CMD_WRITE, 7'd127, 16'hffff, 8'hff, '1, 3'd7));
		pending_req.push_back(mk(CMD_TX_FAIL));
		pending_req.push_back(sdo_req(CMD_WRITE, 7'd9, 16'h6040, 8'h00, $urandom, 3'd2));
		pending_req.push_back(mk(CMD_RX_FAIL));
		pending_req.push_back(sdo_req(CMD_READ, 7'd9, 16'h6041, 8'h00, '0, '0));
		pending_req.push_back(rx_frame(1'b0, 11'h589, {$urandom, 24'h0, 8'h80}));

		// zero error limit judges the first error frame, limit one judges a foreign frame
		set_config(32'd0, 32'hffffffff, 8'd0, 8'd1);
		pending_req.push_back(sdo_req(CMD_READ, 7'd3, 16'h1018, 8'h01, '0, '0));
		pending_req.push_back(rx_frame(1'b1, 11'h100, {32'hdeadbeef, 24'h0, 8'h43}));
		pending_req.push_back(sdo_req(CMD_WRITE, 7'd3, 16'habcd, 8'h02, $urandom, 3'd4));
		pending_req.push_back(rx_frame(1'b0, 11'h100, {40'h0, 24'habcd60}));
		push_random(150);

		set_config(32'hffffffff, 32'd0, 8'd255, 8'd255);
		send_idle_pct = 46;
		recv_stall_pct = 20;
		push_random(150);

		set_config($urandom, $urandom, 8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)));
		push_random(160);

		set_config($urandom, $urandom, 8'd1, 8'($urandom_range(2, 4)));
		send_idle_pct = 0;
		recv_stall_pct = 0;
		push_random(170);

		settle();
		repeat (10) @(posedge clk);
		$display("run covered %0d requests, %0d results checked, %0d exchange completions,",
			n_req, n_rsp, n_done);
		$display("over five register settings and three handshake pacing modes");
		if (n_err == 0 && awaited_rsp.size() == 0)
			$display("** canopen_sdo_nmt_master_unit: PASSED **");
		else
			$display("** canopen_sdo_nmt_master_unit: FAILED **");
		$finish;
	end

endmodule
